/* hw/rtl/lsc_pkg.sv */
// Package for the lidar scan to Cartesian converter.
// Widths, CORDIC arctangent table and shared types. No dependencies.
package lsc_pkg;

	localparam int RANGE_W   = 16;
	localparam int INDEX_W   = 12;
	localparam int STEP_W    = 24;
	localparam int PHASE_W   = 24;
	localparam int COORD_W   = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;
	localparam int GAIN_W    = 20;
	localparam int PROD_W    = RANGE_W + GAIN_W;
	localparam int VEC_W     = 27;
	localparam int ANG_W     = 32;
	localparam int ITERS     = 20;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;

	localparam logic [GAIN_W-1:0] GAIN_Q20 = 20'd636751;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT = 2'd1;
	localparam logic [STEP_W-1:0]  ANGLE_STEP_RST  = 24'd4660;
	localparam logic [RANGE_W-1:0] RANGE_LIMIT_RST = 16'd4096;

	localparam logic signed [ANG_W-1:0] ATAN_T [ITERS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756, 32'sd42667331,
		32'sd21354465, 32'sd10679838, 32'sd5340245, 32'sd2670163, 32'sd1335087,
		32'sd667544, 32'sd333772, 32'sd166886, 32'sd83443, 32'sd41722,
		32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304
	};

	typedef struct packed {
		logic [RANGE_W-1:0]      r;
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} lsc_item_t;

	typedef struct packed {
		logic push;
	} lsc_qctl_t;

endpackage

/* hw/rtl/lsc_front.sv */
// Front end: config registers, clamp, phase and gain products, quadrant fold.
// Depends on lsc_pkg.
module lsc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsc_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsc_pkg::RANGE_W-1:0]   range_sample,
	input  logic                          range_infinite,
	input  logic [lsc_pkg::INDEX_W-1:0]   sample_index,
	input  logic                          q_full,
	output lsc_pkg::lsc_item_t            item,
	output logic                          push
);
	import lsc_pkg::*;

	logic [STEP_W-1:0]  angle_step_q;
	logic [RANGE_W-1:0] range_limit_q;
	logic               adv;
	logic               v_s1, v_s2;
	logic [RANGE_W-1:0] r_s1;
	logic [PROD_W-1:0]  gain_s1;
	logic [PHASE_W-1:0] phase_s1;
	lsc_item_t          item_s2;
	logic [RANGE_W-1:0] r_clamp;
	logic [PROD_W-1:0]  m_full;
	logic signed [VEC_W-1:0] m;
	logic [INDEX_W+STEP_W-1:0] ph_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_step_q  <= ANGLE_STEP_RST;
			range_limit_q <= RANGE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data[STEP_W-1:0];
				REG_RANGE_LIMIT: range_limit_q <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !v_s2 || !q_full;
	assign in_ready = adv;
	assign push     = v_s2 && !q_full;
	assign item     = item_s2;

	assign r_clamp = (range_infinite || range_sample > range_limit_q) ? range_limit_q
	                                                                  : range_sample;
	assign ph_prod = sample_index * angle_step_q;
	assign m_full  = (gain_s1 + PROD_W'(2048)) >> 12;
	assign m       = VEC_W'(m_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1     <= r_clamp;
			gain_s1  <= PROD_W'(r_clamp) * PROD_W'(GAIN_Q20);
			phase_s1 <= ph_prod[PHASE_W-1:0];
			item_s2.r <= r_s1;
			item_s2.z <= ANG_W'({2'b00, phase_s1[PHASE_W-3:0], 8'b0});
			case (phase_s1[PHASE_W-1 -: 2])
				2'd0: begin item_s2.x <= m;  item_s2.y <= '0; end
				2'd1: begin item_s2.x <= '0; item_s2.y <= m;  end
				2'd2: begin item_s2.x <= -m; item_s2.y <= '0; end
				default: begin item_s2.x <= '0; item_s2.y <= -m; end
			endcase
		end
	end

endmodule

/* hw/rtl/lsc_queue.sv */
// Four-entry queue between front end and CORDIC back end.
// Depends on lsc_pkg.
module lsc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  lsc_pkg::lsc_qctl_t ctl_in,
	input  lsc_pkg::lsc_item_t wr_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output lsc_pkg::lsc_item_t rd_item
);
	import lsc_pkg::*;

	lsc_item_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full    = count_q == (QPTR_W+1)'(QDEPTH);
	assign empty   = count_q == '0;
	assign rd_item = mem_q[rd_ptr_q];
	assign do_push = ctl_in.push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

/* hw/rtl/lsc_back.sv */
// Back end: 20-stage pipelined CORDIC rotation, rounding and saturation.
// Depends on lsc_pkg.
module lsc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  lsc_pkg::lsc_item_t                q_item,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lsc_pkg::RANGE_W-1:0]       clamped_range,
	output logic signed [lsc_pkg::COORD_W-1:0] x_coord,
	output logic signed [lsc_pkg::COORD_W-1:0] y_coord
);
	import lsc_pkg::*;

	lsc_item_t st_s [ITERS+1];
	logic      v_s  [ITERS+1];
	logic      adv;

	function automatic logic signed [COORD_W-1:0] pack(input logic signed [VEC_W-1:0] v);
		logic signed [VEC_W:0] t;
		logic signed [VEC_W-8:0] s;
		t = {v[VEC_W-1], v} + (VEC_W+1)'(128);
		s = t[VEC_W:8];
		if (s > (VEC_W-7)'(65535))       pack = COORD_W'(65535);
		else if (s < -(VEC_W-7)'(65535)) pack = -COORD_W'(65535);
		else                              pack = s[COORD_W-1:0];
	endfunction

	assign adv = !v_s[ITERS] || out_ready;
	assign pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= ITERS; k++) v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= !q_empty;
			for (int k = 0; k < ITERS; k++) v_s[k+1] <= v_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) st_s[0] <= q_item;
	end

	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		lsc_item_t nxt;
		always_comb begin
			nxt.r = st_s[i].r;
			if (!st_s[i].z[ANG_W-1]) begin
				nxt.x = st_s[i].x - (st_s[i].y >>> i);
				nxt.y = st_s[i].y + (st_s[i].x >>> i);
				nxt.z = st_s[i].z - ATAN_T[i];
			end else begin
				nxt.x = st_s[i].x + (st_s[i].y >>> i);
				nxt.y = st_s[i].y - (st_s[i].x >>> i);
				nxt.z = st_s[i].z + ATAN_T[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) st_s[i+1] <= nxt;
		end
	end

	assign out_valid     = v_s[ITERS];
	assign clamped_range = st_s[ITERS].r;
	assign x_coord       = pack(st_s[ITERS].x);
	assign y_coord       = pack(st_s[ITERS].y);

endmodule

/* hw/rtl/lidar_scan_to_cartesian.sv */
// Top level of the lidar scan to Cartesian converter: front, queue, back.
// Depends on lsc_pkg, lsc_front, lsc_queue, lsc_back.
//
//  channel | handshake            | payload
//  input   | in_valid / in_ready   | range_sample, range_infinite, sample_index
//  output  | out_valid / out_ready | clamped_range, x_coord, y_coord
//  config  | cfg_we                | cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready stays high; a result passes
// through two front stages (the first loaded at the input edge), one queue
// slot, the CORDIC entry register and 20 CORDIC stages.
// Reset clears all valid state and loads register defaults.
// An output stall freezes the CORDIC pipe; the four-entry queue then fills
// before in_ready drops.
module lidar_scan_to_cartesian (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsc_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lsc_pkg::RANGE_W-1:0]        range_sample,
	input  logic                               range_infinite,
	input  logic [lsc_pkg::INDEX_W-1:0]        sample_index,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lsc_pkg::RANGE_W-1:0]        clamped_range,
	output logic signed [lsc_pkg::COORD_W-1:0] x_coord,
	output logic signed [lsc_pkg::COORD_W-1:0] y_coord
);
	import lsc_pkg::*;

	lsc_item_t f_item, q_item;
	lsc_qctl_t qctl;
	logic      push, q_full, q_empty, pop;

	assign qctl.push = push;

	lsc_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .range_sample, .range_infinite, .sample_index,
		.q_full, .item(f_item), .push
	);

	lsc_queue u_queue (
		.clk, .arst_n, .ctl_in(qctl), .wr_item(f_item), .full(q_full),
		.pop, .empty(q_empty), .rd_item(q_item)
	);

	lsc_back u_back (
		.clk, .arst_n, .q_empty, .q_item, .pop,
		.out_valid, .out_ready, .clamped_range, .x_coord, .y_coord
	);

endmodule

/* hw/rtl/lsc_checker.sv */
// Port-level checks for lidar_scan_to_cartesian, bound to the top level.
// Depends on lsc_pkg.
module lsc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [lsc_pkg::RANGE_W-1:0]        clamped_range,
	input logic signed [lsc_pkg::COORD_W-1:0] x_coord,
	input logic signed [lsc_pkg::COORD_W-1:0] y_coord
);
	import lsc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_coord) && $stable(y_coord))
		else $error("stalled output beat changed");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> x_coord != -COORD_W'(65536) && y_coord != -COORD_W'(65536))
		else $error("coordinate beyond saturation");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clamped_range == '0 |-> x_coord == '0 && y_coord == '0)
		else $error("zero range gave nonzero point");

endmodule

bind lidar_scan_to_cartesian lsc_checker u_lsc_checker (
	.clk, .arst_n, .out_valid, .out_ready, .clamped_range, .x_coord, .y_coord
);
